// ===== rtl/bst_pkg.sv =====
// ----------------------------------------------------------------------------
// bst_pkg
// Shared constants, types and helpers for the breakpoint slot table.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int SLOTS      = 16;
  localparam int ADDR_WIDTH = 16;

  localparam int FieldAw    = 16;
  localparam int LimitW     = 5;
  localparam int MaxResults = 16;
  localparam int SlotAw     = (ADDR_WIDTH < FieldAw) ? ADDR_WIDTH : FieldAw;
  localparam int SlotIw     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [SlotIw-1:0] slot_idx_t;
  typedef logic [SlotAw-1:0] slot_addr_t;
  typedef logic [SLOTS-1:0]  slot_vec_t;

  localparam logic [2:0] ActQuery    = 3'd0;
  localparam logic [2:0] ActSet      = 3'd1;
  localparam logic [2:0] ActSetTemp  = 3'd2;
  localparam logic [2:0] ActClear    = 3'd3;
  localparam logic [2:0] ActClearTmp = 3'd4;
  localparam logic [2:0] ActToggle   = 3'd5;
  localparam logic [2:0] ActList     = 3'd6;

  typedef struct packed {
    logic exec;
    logic list_start;
    logic list_emit;
    logic list_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic any_perm;
    logic cand_any;
    logic cand_more;
  } sts_t;

  function automatic slot_idx_t lowest_idx(input slot_vec_t v);
    slot_idx_t idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = slot_idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== rtl/bst_req_if.sv =====
// ----------------------------------------------------------------------------
// bst_req_if
// Request channel: action, address and list limit with valid/ready.
// ----------------------------------------------------------------------------
interface bst_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] address;
  logic [4:0]  list_limit;

  modport source (output valid, output action, output address, output list_limit,
                  input ready);
  modport sink   (input valid, input action, input address, input list_limit,
                  output ready);
endinterface

// ===== rtl/bst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bst_rsp_if
// Response channel: ok, listed address and last flag with valid/ready.
// ----------------------------------------------------------------------------
interface bst_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] listed_address;
  logic        last;

  modport source (output valid, output ok, output listed_address, output last,
                  input ready);
  modport sink   (input valid, input ok, input listed_address, input last,
                  output ready);
endinterface

// ===== rtl/bst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bst_ctrl
// Request sequencer: non-list actions, and the list walk with its count.
// ----------------------------------------------------------------------------
module bst_ctrl
  import bst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic [2:0]  req_action_i,
  input  logic [4:0]  req_list_limit_i,
  output logic        req_ready_o,
  input  sts_t        sts_i,
  output cmd_t        cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StList = 1'b1;

  logic              state_q, state_d;
  logic [LimitW-1:0] rem_q, rem_d;
  logic [LimitW-1:0] limit_cap;
  logic              accept;

  assign limit_cap = (req_list_limit_i > LimitW'(MaxResults)) ? LimitW'(MaxResults)
                                                              : req_list_limit_i;
  assign req_ready_o = (state_q == StIdle) && sts_i.out_free;
  assign accept      = req_ready_o && req_valid_i;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_action_i == ActList && limit_cap != '0 && sts_i.any_perm) begin
            cmd_o.list_start = 1'b1;
            rem_d            = limit_cap;
            state_d          = StList;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      StList: begin
        if (sts_i.out_free) begin
          cmd_o.list_emit = 1'b1;
          cmd_o.list_last = (rem_q == LimitW'(1)) || !sts_i.cand_more;
          rem_d           = rem_q - LimitW'(1);
          if (cmd_o.list_last) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ===== rtl/bst_dp.sv =====
// ----------------------------------------------------------------------------
// bst_dp
// Slot registers, parallel match and free search, list scan and result register.
// ----------------------------------------------------------------------------
module bst_dp
  import bst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  req_action_i,
  input  logic [15:0] req_address_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        rsp_ready_i,
  output logic        rsp_valid_o,
  output logic        rsp_ok_o,
  output logic [15:0] rsp_listed_address_o,
  output logic        rsp_last_o
);

  slot_vec_t  act_q, act_d;
  slot_vec_t  tmp_q, tmp_d;
  slot_vec_t  done_q, done_d;
  slot_addr_t addr_q [SLOTS];

  slot_addr_t a;
  slot_vec_t  match_v, perm_v, cand_v, cand_rest;
  logic       m_found, m_temp, f_found;
  slot_idx_t  m_idx, f_idx, c_idx;

  logic       alloc_en, alloc_temp, free_en, perm_en, ok;

  logic        out_valid_q, ok_q, last_q;
  logic [15:0] listed_q, listed_d;

  assign a = req_address_i[SlotAw-1:0];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match_v[i] = act_q[i] && (addr_q[i] == a);
    end
  end

  assign perm_v  = act_q & ~tmp_q;
  assign cand_v  = perm_v & ~done_q;
  assign m_found = |match_v;
  assign m_idx   = lowest_idx(match_v);
  assign m_temp  = tmp_q[m_idx];
  assign f_found = |(~act_q);
  assign f_idx   = lowest_idx(~act_q);
  assign c_idx   = lowest_idx(cand_v);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cand_rest[i] = cand_v[i] && (slot_idx_t'(i) > c_idx);
    end
  end

  always_comb begin
    alloc_en   = 1'b0;
    alloc_temp = 1'b0;
    free_en    = 1'b0;
    perm_en    = 1'b0;
    ok         = 1'b0;
    unique case (req_action_i)
      ActQuery: ok = m_found;
      ActSet, ActToggle: begin
        if (m_found && !m_temp && req_action_i == ActToggle) begin
          free_en = 1'b1;
          ok      = 1'b1;
        end else if (m_found) begin
          perm_en = 1'b1;
          ok      = m_temp;
        end else begin
          alloc_en = f_found;
          ok       = f_found;
        end
      end
      ActSetTemp: begin
        if (!m_found) begin
          alloc_en   = f_found;
          alloc_temp = 1'b1;
          ok         = f_found;
        end
      end
      ActClear: begin
        free_en = m_found && !m_temp;
        ok      = free_en;
      end
      ActClearTmp: begin
        free_en = m_found && m_temp;
        ok      = free_en;
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    act_d = act_q;
    tmp_d = tmp_q;
    if (cmd_i.exec) begin
      if (alloc_en) begin
        act_d[f_idx] = 1'b1;
        tmp_d[f_idx] = alloc_temp;
      end
      if (free_en) begin
        act_d[m_idx] = 1'b0;
      end
      if (perm_en) begin
        tmp_d[m_idx] = 1'b0;
      end
    end
  end

  always_comb begin
    done_d = done_q;
    if (cmd_i.list_start) begin
      done_d = '0;
    end else if (cmd_i.list_emit) begin
      for (int i = 0; i < SLOTS; i++) begin
        done_d[i] = done_q[i] || (slot_idx_t'(i) <= c_idx);
      end
    end
  end

  always_comb begin
    listed_d                = '0;
    listed_d[SlotAw-1:0]    = addr_q[c_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      tmp_q  <= '0;
      done_q <= '0;
    end else begin
      act_q  <= act_d;
      tmp_q  <= tmp_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && alloc_en) begin
      addr_q[f_idx] <= a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.list_emit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q     <= ok;
      listed_q <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.list_emit) begin
      ok_q     <= 1'b1;
      listed_q <= listed_d;
      last_q   <= cmd_i.list_last;
    end
  end

  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;
  assign sts_o.any_perm  = |perm_v;
  assign sts_o.cand_any  = |cand_v;
  assign sts_o.cand_more = |cand_rest;

  assign rsp_valid_o          = out_valid_q;
  assign rsp_ok_o             = ok_q;
  assign rsp_listed_address_o = listed_q;
  assign rsp_last_o           = last_q;

endmodule

// ===== rtl/breakpoint_slot_table.sv =====
// ----------------------------------------------------------------------------
// breakpoint_slot_table
// Breakpoint slot table with query, set, clear, toggle and list actions.
// ----------------------------------------------------------------------------
// Every action other than list completes in one pass: all slot addresses are
// compared at once against the request, the lowest matching and lowest free
// slots are picked by priority encoders, the slot flags update and the single
// result is registered, so one such item is taken per cycle while the result
// register is free. A list emits, one result at a time, each address that the
// scan finds in the lowest unlisted permanent slot, holding while a result is
// not taken; no item is taken until its last result is loaded. An empty list
// gives one failed result. Reset clears all slots; there is no clearing pass.
module breakpoint_slot_table
  import bst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bst_req_if.sink    req,
  bst_rsp_if.source  rsp
);

  cmd_t cmd;
  sts_t sts;

  bst_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req.valid),
    .req_action_i     (req.action),
    .req_list_limit_i (req.list_limit),
    .req_ready_o      (req.ready),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  bst_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .req_action_i         (req.action),
    .req_address_i        (req.address),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .rsp_ready_i          (rsp.ready),
    .rsp_valid_o          (rsp.valid),
    .rsp_ok_o             (rsp.ok),
    .rsp_listed_address_o (rsp.listed_address),
    .rsp_last_o           (rsp.last)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.exec, cmd.list_start, cmd.list_emit}))
    else $error("more than one datapath command at once");

  a_emit_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.list_emit |-> sts.cand_any)
    else $error("list emit with no permanent slot left");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.list_start |=> !req.ready)
    else $error("request taken during a list");

  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ok) |-> rsp.last)
    else $error("failed result not marked last");

endmodule
